@@ rtl/bipartite_edge_coloring_defines.svh @@
// Assertion macros for the bipartite edge coloring block.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef BIPARTITE_EDGE_COLORING_DEFINES_SVH
`define BIPARTITE_EDGE_COLORING_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define BEC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bec assertion failed");

// Next-cycle implication, quiet during reset
`define BEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bec assertion failed");

`endif

@@ rtl/bec_pkg.sv @@
// Shared types and constants for the bipartite edge coloring block.
// No dependencies; used by the interfaces, the top level and the checker.
package bec_pkg;

    localparam int ROWS       = 64;
    localparam int COLS       = 64;
    localparam int MAXC       = 64;
    localparam int IDX_W      = 6;
    localparam int DATA_W     = 7;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int MEM_AW     = 12;
    localparam int MEM_DEPTH  = 4096;
    localparam int VTX_DEPTH  = 64;
    localparam int STEP_LIMIT = ROWS + COLS + 2;
    localparam int STEP_W     = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_ROWS = 1'b0,
        CFG_ACTIVE_COLS = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_LOOKW,
        S_SCAN,
        S_DEC,
        S_SET,
        S_PRD,
        S_PWR,
        S_PEND,
        S_DEG,
        S_FIN
    } t_state;

endpackage

@@ rtl/bec_in_if.sv @@
// Input item channel: valid/ready with kind, row and column.
// Depends on bec_pkg.
interface bec_in_if import bec_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;

    modport source (output valid, output kind, output row_index, output col_index,
                    input ready);
    modport sink   (input valid, input kind, input row_index, input col_index,
                    output ready);
endinterface

@@ rtl/bec_out_if.sv @@
// Result channel: valid/ready with edge color, max degree and status.
// Depends on bec_pkg.
interface bec_out_if import bec_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] edge_color;
    logic [DATA_W-1:0] max_degree;
    logic              status;

    modport source (output valid, output edge_color, output max_degree, output status,
                    input ready);
    modport sink   (input valid, input edge_color, input max_degree, input status,
                    output ready);
endinterface

@@ rtl/bec_cfg_if.sv @@
// Configuration write channel: valid/ready with register index and data.
// Depends on bec_pkg.
interface bec_cfg_if import bec_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/bipartite_edge_coloring.sv @@
// Online edge coloring of a 64 x 64 bipartite graph. After reset the block runs a clearing
// pass over its tables and takes no item meanwhile; a clear item repeats it, then returns a
// result. An out-of-range or unused item goes straight to S_FIN, a read or duplicate add via
// the lookup states S_LOOK and S_LOOKW. An add does the lookup, a free-color scan over the
// partner memories (row and column scanned together) and a decision; if both ends have a
// free color it sets a common one or flips an alternating path of at most 130 steps, each
// a read (S_PRD) and a write (S_PWR), as each step reads one partner memory and writes all
// three tables through their single ports. One item is worked on at a time; the next one
// is accepted while the previous result waits in the output register. Configuration writes
// are always accepted. Depends on bec_pkg and the three channel interfaces.
module bipartite_edge_coloring import bec_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    bec_in_if.sink    i_in,
    bec_out_if.source o_out,
    bec_cfg_if.sink   i_cfg
);

    t_state r_state, n_state;

    // table memories
    logic [DATA_W-1:0] rp_mem [MEM_DEPTH];
    logic [DATA_W-1:0] cp_mem [MEM_DEPTH];
    logic [DATA_W-1:0] cc_mem [MEM_DEPTH];
    logic [DATA_W-1:0] rd_mem [VTX_DEPTH];
    logic [DATA_W-1:0] cd_mem [VTX_DEPTH];

    logic              rp_we, cp_we, cc_we, rd_we, cd_we;
    logic [MEM_AW-1:0] rp_wa, cp_wa, cc_wa, rp_ra, cp_ra, cc_ra;
    logic [IDX_W-1:0]  rd_wa, cd_wa;
    logic [DATA_W-1:0] rp_wd, cp_wd, cc_wd, rd_wd, cd_wd;
    logic [DATA_W-1:0] rp_q, cp_q, cc_q, rd_q, cd_q;

    logic [DATA_W-1:0] r_act_rows, r_act_cols;
    t_kind             r_kind;
    logic [IDX_W-1:0]  r_row, r_col;
    logic [MEM_AW-1:0] r_clr_cnt;
    logic              r_clr_emit;
    logic [DATA_W-1:0] r_rdeg, r_cdeg, r_peak;
    logic [DATA_W-1:0] r_cnt;
    logic              r_xf, r_yf;
    logic [DATA_W-1:0] r_x, r_y;
    logic [IDX_W-1:0]  r_u, r_v;
    logic [DATA_W-1:0] r_a, r_b;
    logic              r_side;
    logic [STEP_W-1:0] r_steps;
    logic [DATA_W-1:0] r_res_color;
    logic              r_res_status;
    logic              r_ov;
    logic [DATA_W-1:0] r_o_color, r_o_deg;
    logic              r_o_status;

    logic              in_acc, in_range, out_load;
    logic              n_xf, n_yf, path_end;
    logic [DATA_W-1:0] n_x, n_y, w, am1, bm1, xm1, u_p1, v_p1, rdeg_p1, cdeg_p1;

    assign in_acc   = i_in.valid && i_in.ready;
    assign in_range = ({1'b0, i_in.row_index} < r_act_rows) &&
                      ({1'b0, i_in.col_index} < r_act_cols);
    assign out_load = (r_state == S_FIN) && (!r_ov || o_out.ready);

    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_ov;
    assign o_out.edge_color = r_o_color;
    assign o_out.max_degree = r_o_deg;
    assign o_out.status    = r_o_status;

    assign am1     = r_a - DATA_W'(1);
    assign bm1     = r_b - DATA_W'(1);
    assign xm1     = r_x - DATA_W'(1);
    assign u_p1    = {1'b0, r_u} + DATA_W'(1);
    assign v_p1    = {1'b0, r_v} + DATA_W'(1);
    assign rdeg_p1 = r_rdeg + DATA_W'(1);
    assign cdeg_p1 = r_cdeg + DATA_W'(1);
    assign w       = r_side ? rp_q : cp_q;
    assign path_end = (w == '0) || (w > DATA_W'(MAXC));

    // scan evaluates the data read for color r_cnt, whose read was issued in the cycle before
    always_comb begin
        n_xf = r_xf;
        n_x  = r_x;
        n_yf = r_yf;
        n_y  = r_y;
        if (r_cnt != '0) begin
            if (!r_xf && rp_q == '0) begin
                n_xf = 1'b1;
                n_x  = r_cnt;
            end
            if (!r_yf && cp_q == '0) begin
                n_yf = 1'b1;
                n_y  = r_cnt;
            end
        end
    end

    // memories: synchronous write, registered read
    always_ff @(posedge i_clk) begin
        if (rp_we) rp_mem[rp_wa] <= rp_wd;
        if (cp_we) cp_mem[cp_wa] <= cp_wd;
        if (cc_we) cc_mem[cc_wa] <= cc_wd;
        if (rd_we) rd_mem[rd_wa] <= rd_wd;
        if (cd_we) cd_mem[cd_wa] <= cd_wd;
        rp_q <= rp_mem[rp_ra];
        cp_q <= cp_mem[cp_ra];
        cc_q <= cc_mem[cc_ra];
        rd_q <= rd_mem[r_row];
        cd_q <= cd_mem[r_col];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        rp_we = 1'b0;  rp_wa = {r_row, r_cnt[IDX_W-1:0]};  rp_wd = '0;
        cp_we = 1'b0;  cp_wa = {r_col, r_cnt[IDX_W-1:0]};  cp_wd = '0;
        cc_we = 1'b0;  cc_wa = {r_row, r_col};              cc_wd = '0;
        rd_we = 1'b0;  rd_wa = r_row;                       rd_wd = rdeg_p1;
        cd_we = 1'b0;  cd_wa = r_col;                       cd_wd = cdeg_p1;
        rp_ra = {r_row, r_cnt[IDX_W-1:0]};
        cp_ra = {r_col, r_cnt[IDX_W-1:0]};
        cc_ra = {r_row, r_col};
        case (r_state)
            S_CLEAR: begin
                rp_we = 1'b1;  rp_wa = r_clr_cnt;
                cp_we = 1'b1;  cp_wa = r_clr_cnt;
                cc_we = 1'b1;  cc_wa = r_clr_cnt;
                rd_we = 1'b1;  rd_wa = r_clr_cnt[IDX_W-1:0];  rd_wd = '0;
                cd_we = 1'b1;  cd_wa = r_clr_cnt[IDX_W-1:0];  cd_wd = '0;
                if (r_clr_cnt == MEM_AW'(MEM_DEPTH - 1))
                    n_state = r_clr_emit ? S_FIN : S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (t_kind'(i_in.kind) == KIND_CLEAR)
                        n_state = S_CLEAR;
                    else if (t_kind'(i_in.kind) == KIND_NONE || !in_range)
                        n_state = S_FIN;
                    else
                        n_state = S_LOOK;
                end
            end
            S_LOOK: n_state = S_LOOKW;
            S_LOOKW: begin
                if (r_kind == KIND_READ || cc_q != '0)
                    n_state = S_FIN;
                else
                    n_state = S_SCAN;
            end
            S_SCAN: begin
                if ((n_xf && n_yf) || r_cnt == DATA_W'(MAXC))
                    n_state = S_DEC;
            end
            S_DEC: begin
                if (!r_xf || !r_yf)
                    n_state = S_DEG;
                else if (r_x == r_y)
                    n_state = S_SET;
                else
                    n_state = S_PRD;
            end
            S_SET: begin
                cc_we = 1'b1;  cc_wd = r_x;
                rp_we = 1'b1;  rp_wa = {r_row, xm1[IDX_W-1:0]};
                rp_wd = {1'b0, r_col} + DATA_W'(1);
                cp_we = 1'b1;  cp_wa = {r_col, xm1[IDX_W-1:0]};
                cp_wd = {1'b0, r_row} + DATA_W'(1);
                n_state = S_DEG;
            end
            S_PRD: begin
                rp_ra = {r_v, am1[IDX_W-1:0]};
                cp_ra = {r_v, am1[IDX_W-1:0]};
                n_state = S_PWR;
            end
            S_PWR: begin
                // side 0: u is a row, v a column; side 1 swaps the roles
                rp_we = 1'b1;
                rp_wa = r_side ? {r_v, am1[IDX_W-1:0]} : {r_u, am1[IDX_W-1:0]};
                rp_wd = r_side ? u_p1 : v_p1;
                cp_we = 1'b1;
                cp_wa = r_side ? {r_u, am1[IDX_W-1:0]} : {r_v, am1[IDX_W-1:0]};
                cp_wd = r_side ? v_p1 : u_p1;
                cc_we = 1'b1;
                cc_wa = r_side ? {r_v, r_u} : {r_u, r_v};
                cc_wd = r_a;
                if (path_end)
                    n_state = S_PEND;
                else if (r_steps == STEP_W'(STEP_LIMIT - 1))
                    n_state = S_DEG;
                else
                    n_state = S_PRD;
            end
            S_PEND: begin
                // free the other color at the path's last vertex
                if (r_side) begin
                    rp_we = 1'b1;  rp_wa = {r_v, bm1[IDX_W-1:0]};
                end else begin
                    cp_we = 1'b1;  cp_wa = {r_v, bm1[IDX_W-1:0]};
                end
                n_state = S_DEG;
            end
            S_DEG: begin
                rd_we = 1'b1;
                cd_we = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_rows <= DATA_W'(ROWS);
            r_act_cols <= DATA_W'(COLS);
            r_clr_cnt  <= '0;
            r_clr_emit <= 1'b0;
            r_peak     <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_ACTIVE_ROWS: r_act_rows <= i_cfg.data;
                    CFG_ACTIVE_COLS: r_act_cols <= i_cfg.data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_ov       <= 1'b1;
                r_o_color  <= r_res_color;
                r_o_deg    <= r_peak;
                r_o_status <= r_res_status;
            end else if (o_out.valid && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLEAR: r_clr_cnt <= r_clr_cnt + MEM_AW'(1);
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind       <= t_kind'(i_in.kind);
                        r_row        <= i_in.row_index;
                        r_col        <= i_in.col_index;
                        r_res_color  <= '0;
                        r_res_status <= (t_kind'(i_in.kind) != KIND_CLEAR);
                        if (t_kind'(i_in.kind) == KIND_CLEAR) begin
                            r_clr_emit   <= 1'b1;
                            r_clr_cnt    <= '0;
                            r_peak       <= '0;
                        end
                    end
                end
                S_LOOKW: begin
                    r_rdeg       <= rd_q;
                    r_cdeg       <= cd_q;
                    r_res_color  <= cc_q;
                    r_res_status <= (r_kind == KIND_ADD) && (cc_q != '0);
                    r_cnt        <= '0;
                    r_xf         <= 1'b0;
                    r_yf         <= 1'b0;
                end
                S_SCAN: begin
                    r_xf  <= n_xf;
                    r_x   <= n_x;
                    r_yf  <= n_yf;
                    r_y   <= n_y;
                    r_cnt <= r_cnt + DATA_W'(1);
                end
                S_DEC: begin
                    r_res_color  <= (r_xf && r_yf) ? r_x : '0;
                    r_res_status <= 1'b0;
                    r_u     <= r_row;
                    r_v     <= r_col;
                    r_a     <= r_x;
                    r_b     <= r_y;
                    r_side  <= 1'b0;
                    r_steps <= '0;
                end
                S_PWR: begin
                    if (!path_end) begin
                        r_a     <= r_b;
                        r_b     <= r_a;
                        r_side  <= ~r_side;
                        r_u     <= r_v;
                        r_v     <= w[IDX_W-1:0] - IDX_W'(1);
                        r_steps <= r_steps + STEP_W'(1);
                    end
                end
                S_DEG: begin
                    if (rdeg_p1 > r_peak && rdeg_p1 >= cdeg_p1)
                        r_peak <= rdeg_p1;
                    else if (cdeg_p1 > r_peak)
                        r_peak <= cdeg_p1;
                end
                S_FIN: r_clr_emit <= 1'b0;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/bec_checker.sv @@
// Port checker for the bipartite edge coloring block, bound to the top level.
// Depends on bec_pkg and bipartite_edge_coloring_defines.svh.
`include "bipartite_edge_coloring_defines.svh"

module bec_checker import bec_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_out_edge_color,
    input logic [DATA_W-1:0] i_out_max_degree,
    input logic              i_out_status
);

    `BEC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `BEC_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_edge_color) && $stable(i_out_max_degree) && $stable(i_out_status))
    `BEC_ASSERT_NEXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready)
    `BEC_ASSERT_NOW(a_color_bound, i_out_valid, i_out_edge_color <= i_out_max_degree)
    `BEC_ASSERT_NOW(a_degree_bound, i_out_valid, i_out_max_degree <= DATA_W'(MAXC))

endmodule

bind bipartite_edge_coloring bec_checker u_bec_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_edge_color (o_out.edge_color),
    .i_out_max_degree (o_out.max_degree),
    .i_out_status     (o_out.status)
);

@@ tb/sv/edge_coloring_checker.sv @@
// Checker for the bipartite edge coloring block: keeps its own copy of the coloring
// tables, predicts each result and compares it with what the block returns.
// Depends on bec_pkg and the three channel interfaces.
module edge_coloring_checker import bec_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bec_in_if    i_in,
    bec_out_if   i_out,
    bec_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending,
    output int   o_results,
    output int   o_path_adds
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] edge_color;
        logic [DATA_W-1:0] max_degree;
        logic              status;
    } coloring_result_t;

    coloring_result_t color_q[$];

    bit [DATA_W-1:0] row_link[ROWS][MAXC];
    bit [DATA_W-1:0] col_link[COLS][MAXC];
    bit [DATA_W-1:0] edge_tab[ROWS][COLS];
    bit [DATA_W-1:0] row_deg[ROWS];
    bit [DATA_W-1:0] col_deg[COLS];
    bit [DATA_W-1:0] peak_deg;
    int              rows_on;
    int              cols_on;

    function automatic void wipe_tables();
        for (int i = 0; i < ROWS; i++) begin
            row_deg[i] = '0;
            for (int j = 0; j < MAXC; j++) begin
                row_link[i][j] = '0;
                col_link[i][j] = '0;
                edge_tab[i][j] = '0;
            end
        end
        foreach (col_deg[i]) col_deg[i] = '0;
        peak_deg = '0;
    endfunction

    // Lowest color with no partner on a row (on_col=0) or a column (on_col=1)
    function automatic int first_free(bit on_col, int v);
        int c;
        c = 1;
        while (c <= MAXC && (on_col ? col_link[v][c-1] : row_link[v][c-1]) != 0)
            c++;
        return c;
    endfunction

    function automatic int color_new_edge(int r, int k);
        int x, y, a, b, t, u, v, w, side;
        x = first_free(1'b0, r);
        y = first_free(1'b1, k);
        if (x > MAXC || y > MAXC)
            return 0;
        if (x == y) begin
            edge_tab[r][k] = DATA_W'(x);
            row_link[r][x-1] = DATA_W'(k + 1);
            col_link[k][x-1] = DATA_W'(r + 1);
            return x;
        end
        o_path_adds++;
        // flip the x/y alternating path that starts at the column
        side = 0; u = r; v = k; a = x; b = y;
        for (int s = 0; s < STEP_LIMIT; s++) begin
            if (side == 0) begin
                w = int'(col_link[v][a-1]);
                row_link[u][a-1] = DATA_W'(v + 1);
                col_link[v][a-1] = DATA_W'(u + 1);
                edge_tab[u][v] = DATA_W'(a);
                if (w == 0 || w > ROWS) begin
                    col_link[v][b-1] = '0;
                    break;
                end
            end else begin
                w = int'(row_link[v][a-1]);
                col_link[u][a-1] = DATA_W'(v + 1);
                row_link[v][a-1] = DATA_W'(u + 1);
                edge_tab[v][u] = DATA_W'(a);
                if (w == 0 || w > COLS) begin
                    row_link[v][b-1] = '0;
                    break;
                end
            end
            t = a; a = b; b = t;
            side ^= 1;
            u = v;
            v = w - 1;
        end
        return x;
    endfunction

    function automatic coloring_result_t predict_color(t_kind kind, int r, int k);
        coloring_result_t res;
        int lim_r, lim_c;
        bit in_range;
        lim_r = rows_on < ROWS ? rows_on : ROWS;
        lim_c = cols_on < COLS ? cols_on : COLS;
        in_range = (r < lim_r) && (k < lim_c);
        res = '0;
        case (kind)
            KIND_CLEAR: wipe_tables();
            KIND_ADD: begin
                if (!in_range) begin
                    res.status = 1'b1;
                end else if (edge_tab[r][k] != 0) begin
                    res.edge_color = edge_tab[r][k];
                    res.status = 1'b1;
                end else begin
                    res.edge_color = DATA_W'(color_new_edge(r, k));
                    row_deg[r]++;
                    col_deg[k]++;
                    if (row_deg[r] > peak_deg) peak_deg = row_deg[r];
                    if (col_deg[k] > peak_deg) peak_deg = col_deg[k];
                end
            end
            KIND_READ: begin
                if (!in_range) res.status = 1'b1;
                else res.edge_color = edge_tab[r][k];
            end
            default: res.status = 1'b1;
        endcase
        res.max_degree = peak_deg;
        return res;
    endfunction

    always @(posedge i_clk) begin
        coloring_result_t want;
        if (!i_rst_n) begin
            rows_on = ROWS;
            cols_on = COLS;
            wipe_tables();
            color_q.delete();
            o_errors = 0;
            o_results = 0;
            o_path_adds = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_ACTIVE_ROWS: rows_on = int'(i_cfg.data);
                    CFG_ACTIVE_COLS: cols_on = int'(i_cfg.data);
                    default: ;
                endcase
            end
            // retire first: a result never belongs to the transaction of the same edge
            if (i_out.valid && i_out.ready) begin
                o_results++;
                if (color_q.size() == 0) begin
                    $error("result with nothing expected: color %0d degree %0d status %0d",
                           i_out.edge_color, i_out.max_degree, i_out.status);
                    o_errors++;
                end else begin
                    want = color_q.pop_front();
                    if (i_out.edge_color !== want.edge_color) begin
                        $error("edge_color: expected %0d, got %0d",
                               want.edge_color, i_out.edge_color);
                        o_errors++;
                    end
                    if (i_out.max_degree !== want.max_degree) begin
                        $error("max_degree: expected %0d, got %0d",
                               want.max_degree, i_out.max_degree);
                        o_errors++;
                    end
                    if (i_out.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out.status);
                        o_errors++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                color_q.push_back(predict_color(t_kind'(i_in.kind), int'(i_in.row_index),
                                                int'(i_in.col_index)));
        end
        o_pending = color_q.size();
    end

endmodule

@@ tb/sv/tb_bipartite_edge_coloring.sv @@
// Top of the bipartite edge coloring testbench: clock, reset, stimulus and verdict.
// Depends on bec_pkg, the channel interfaces, the block and edge_coloring_checker.
module tb_bipartite_edge_coloring;
    timeunit 1ns;
    timeprecision 1ps;
    import bec_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   n_errors, n_pending, n_results, n_path_adds;
    int   n_items = 0;
    int   n_settings = 0;
    int   lim_r = ROWS;
    int   lim_c = COLS;
    bit   sink_calm = 1'b0;
    bit   source_calm = 1'b0;

    bec_in_if  in_ch();
    bec_out_if out_ch();
    bec_cfg_if cfg_ch();

    bipartite_edge_coloring dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    edge_coloring_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg       (cfg_ch),
        .o_errors    (n_errors),
        .o_pending   (n_pending),
        .o_results   (n_results),
        .o_path_adds (n_path_adds)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #48_000_000;
        $display("tb_bipartite_edge_coloring: done, errors");
        $finish;
    end

    function automatic int pick_gap(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result-side backpressure
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
            if (!sink_calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap(1'b0) + 1;
        end
    end

    // Keep valid high across back-to-back transactions; drop it only in a gap
    task automatic send_item(t_kind kind, int r, int k);
        int gap;
        gap = pick_gap(source_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.row_index <= r[IDX_W-1:0];
        in_ch.col_index <= k[IDX_W-1:0];
        do @(posedge i_clk); while (!in_ch.ready);
        n_items++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (n_pending != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_ranges(int rows, int cols);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_ACTIVE_ROWS;
        cfg_ch.data  <= rows[DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.index <= CFG_ACTIVE_COLS;
        cfg_ch.data  <= cols[DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        lim_r = rows > ROWS ? ROWS : rows;
        lim_c = cols > COLS ? COLS : cols;
        n_settings++;
    endtask

    task automatic random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 72)
            send_item(KIND_ADD, $urandom_range(0, lim_r - 1), $urandom_range(0, lim_c - 1));
        else if (roll < 86)
            send_item(KIND_READ, $urandom_range(0, lim_r - 1), $urandom_range(0, lim_c - 1));
        else if (roll < 97)
            send_item(roll[0] ? KIND_ADD : KIND_READ, $urandom_range(0, 63),
                      $urandom_range(0, 63));
        else
            send_item(KIND_NONE, $urandom_range(0, 63), $urandom_range(0, 63));
    endtask

    int setting_rows[6] = '{8, 4, 64, 16, 2, 64};
    int setting_cols[6] = '{8, 6, 64, 3, 64, 1};

    initial begin
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_CLEAR;
        in_ch.row_index = '0;
        in_ch.col_index = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_ACTIVE_ROWS;
        cfg_ch.data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, duplicates, a path flip, unused kind, clear
        send_item(KIND_READ, 0, 0);
        send_item(KIND_ADD, 0, 0);
        send_item(KIND_ADD, 0, 0);
        send_item(KIND_ADD, 63, 63);
        send_item(KIND_ADD, 0, 63);
        send_item(KIND_ADD, 63, 0);
        send_item(KIND_ADD, 63, 63);
        send_item(KIND_READ, 63, 0);
        send_item(KIND_ADD, 1, 1);
        send_item(KIND_ADD, 1, 2);
        send_item(KIND_ADD, 0, 2);
        send_item(KIND_READ, 1, 2);
        send_item(KIND_NONE, 63, 63);
        send_item(KIND_CLEAR, 63, 63);
        send_item(KIND_READ, 0, 0);
        drain();
        write_ranges(1, 1);
        send_item(KIND_ADD, 1, 0);
        send_item(KIND_ADD, 0, 1);
        send_item(KIND_ADD, 0, 0);
        send_item(KIND_READ, 0, 0);
        drain();
        write_ranges(0, 0);
        send_item(KIND_ADD, 0, 0);
        send_item(KIND_READ, 0, 0);
        drain();
        write_ranges(127, 127);
        send_item(KIND_ADD, 63, 62);
        send_item(KIND_READ, 0, 0);
        drain();

        // random phases, each starting from empty tables
        for (int p = 0; p < 6; p++) begin
            write_ranges(setting_rows[p], setting_cols[p]);
            sink_calm = (p == 2);
            source_calm = (p == 2) || (p == 4);
            send_item(KIND_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
            for (int i = 0; i < 82; i++)
                random_item();
            drain();
        end
        sink_calm = 1'b0;
        source_calm = 1'b0;

        drain();
        repeat (40) @(posedge i_clk);
        $display("covered %0d items (%0d with path flips), %0d results, %0d range settings",
                 n_items, n_path_adds, n_results, n_settings);
        if (n_errors == 0)
            $display("tb_bipartite_edge_coloring: done, clean");
        else
            $display("tb_bipartite_edge_coloring: done, errors");
        $finish;
    end

endmodule
